>>> src/secant_homing_controller_unit_defines.svh
// Assertion macros for the secant homing controller.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef SECANT_HOMING_CONTROLLER_UNIT_DEFINES_SVH
`define SECANT_HOMING_CONTROLLER_UNIT_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define SHC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define SHC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/shc_pkg.sv
// Shared widths, codes and types of the secant homing controller.
// No dependencies; imported by every module of the block.
package shc_pkg;

	localparam int ANGLE_WIDTH     = 16;
	localparam int TIME_FRAC_BITS  = 8;
	localparam int MT_WIDTH        = 16 + TIME_FRAC_BITS;
	localparam int STEP_WIDTH      = 12;
	localparam int ITER_WIDTH      = 13;
	localparam int TOL_WIDTH       = 14;
	localparam int DUR_WIDTH       = 25;
	localparam int CFG_DATA_WIDTH  = 14;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int TICKS_PER_UNIT  = 1150;
	localparam int DIVERGE_FACTOR  = 5;

	localparam logic [STEP_WIDTH-1:0] STEP_TIME_RST = STEP_WIDTH'(10);
	localparam logic [ITER_WIDTH-1:0] MAX_ITER_RST  = ITER_WIDTH'(10);
	localparam logic [TOL_WIDTH-1:0]  TOLERANCE_RST = TOL_WIDTH'(102);

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STEP_TIME = CFG_INDEX_WIDTH'(0);
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_ITER  = CFG_INDEX_WIDTH'(1);
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TOLERANCE = CFG_INDEX_WIDTH'(2);

	typedef enum logic [1:0] {
		DRV_NONE = 2'd0,
		DRV_CW   = 2'd1,
		DRV_CCW  = 2'd2
	} drive_t;

	typedef enum logic [1:0] {
		ST_IDLE      = 2'd0,
		ST_MOVING    = 2'd1,
		ST_CONVERGED = 2'd2,
		ST_LIMIT     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		LANE_HOLD   = 2'd0,
		LANE_START  = 2'd1,
		LANE_REFINE = 2'd2
	} lane_mode_t;

	typedef enum logic [2:0] {
		L_IDLE,
		L_MUL,
		L_DIV,
		L_FIX,
		L_OUT
	} lane_state_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_BUSY,
		T_MERGE
	} top_state_t;

	typedef struct packed {
		drive_t                 drive;
		logic [DUR_WIDTH-1:0]   duration;
		logic                   in_tol;
	} lane_res_t;

	typedef struct packed {
		status_t status;
		logic    run_active;
		logic    iter_inc;
	} merge_ctl_t;

endpackage

>>> src/shc_lane.sv
// One axis of the homing controller: secant refinement of the move time
// with a two-bit-per-cycle restoring divider, then the motor command.
// Depends on shc_pkg.
module shc_lane
	import shc_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  lane_mode_t                    mode,
	input  logic signed [ANGLE_WIDTH-1:0] angle,
	input  logic [STEP_WIDTH-1:0]         step_time,
	input  logic [TOL_WIDTH-1:0]          tolerance,
	output logic                          done,
	output lane_res_t                     res
);

	localparam int PROD_WIDTH = ANGLE_WIDTH + MT_WIDTH;
	localparam int DVS_WIDTH  = ANGLE_WIDTH + 1;
	localparam int REM_WIDTH  = DVS_WIDTH + 1;
	localparam int DIV_STEPS  = PROD_WIDTH / 2;
	localparam int CNT_WIDTH  = $clog2(DIV_STEPS);
	localparam int NOM_WIDTH  = STEP_WIDTH + TIME_FRAC_BITS;
	localparam int LIM_WIDTH  = NOM_WIDTH + 3;
	localparam int TICK_WIDTH = $clog2(TICKS_PER_UNIT + 1);
	localparam int DPROD_W    = MT_WIDTH + TICK_WIDTH;
	localparam int CMP_WIDTH  = (ANGLE_WIDTH > TOL_WIDTH) ? ANGLE_WIDTH : TOL_WIDTH;
	localparam int STEP_W     = REM_WIDTH + PROD_WIDTH;

	lane_state_t                   state_q, state_d;
	lane_mode_t                    mode_q;
	logic signed [ANGLE_WIDTH-1:0] angle_q;
	logic signed [ANGLE_WIDTH-1:0] last_q;
	logic signed [MT_WIDTH-1:0]    mt_q;
	logic [PROD_WIDTH-1:0]         dvd_q;
	logic [REM_WIDTH-1:0]          rem_q;
	logic [DVS_WIDTH-1:0]          dvs_q;
	logic                          neg_q;
	logic                          zero_q;
	logic [CNT_WIDTH-1:0]          cnt_q;
	logic                          done_q;
	lane_res_t                     res_q;

	logic capture_en, mul_en, div_en, fix_en, out_en;

	logic signed [MT_WIDTH-1:0]    nominal;
	logic [NOM_WIDTH-1:0]          nom_u;
	logic [LIM_WIDTH-1:0]          limit;
	logic [ANGLE_WIDTH-1:0]        ang_mag;
	logic [MT_WIDTH-1:0]           mt_mag;
	logic [PROD_WIDTH-1:0]         prod_mag;
	logic signed [DVS_WIDTH-1:0]   diff;
	logic [DVS_WIDTH-1:0]          diff_mag;
	logic [STEP_W-1:0]             step1, step2;
	logic                          over;
	logic signed [MT_WIDTH-1:0]    q_val;
	logic signed [MT_WIDTH-1:0]    mt_next;
	logic [DPROD_W-1:0]            dur_prod;
	logic                          in_tol;

	function automatic logic [STEP_W-1:0] div_step(
		input logic [REM_WIDTH-1:0]  rem,
		input logic [PROD_WIDTH-1:0] dvd,
		input logic [DVS_WIDTH-1:0]  dvs
	);
		logic [REM_WIDTH-1:0] trial;
		logic                 qbit;
		trial = {rem[REM_WIDTH-2:0], dvd[PROD_WIDTH-1]};
		qbit  = (trial >= REM_WIDTH'(dvs));
		if (qbit) begin
			trial = trial - REM_WIDTH'(dvs);
		end
		return {trial, dvd[PROD_WIDTH-2:0], qbit};
	endfunction

	assign nom_u   = {step_time, TIME_FRAC_BITS'(0)};
	assign nominal = MT_WIDTH'(nom_u);
	assign limit   = LIM_WIDTH'(nom_u) * LIM_WIDTH'(DIVERGE_FACTOR);

	assign ang_mag  = angle_q[ANGLE_WIDTH-1] ? ANGLE_WIDTH'(-angle_q) : ANGLE_WIDTH'(angle_q);
	assign mt_mag   = mt_q[MT_WIDTH-1] ? MT_WIDTH'(-mt_q) : MT_WIDTH'(mt_q);
	// magnitudes multiply, the sign is tracked apart
	assign prod_mag = PROD_WIDTH'(ang_mag) * PROD_WIDTH'(mt_mag);
	assign diff     = DVS_WIDTH'(angle_q) - DVS_WIDTH'(last_q);
	assign diff_mag = diff[DVS_WIDTH-1] ? DVS_WIDTH'(-diff) : DVS_WIDTH'(diff);

	assign step1 = div_step(rem_q, dvd_q, dvs_q);
	assign step2 = div_step(step1[STEP_W-1 -: REM_WIDTH], step1[PROD_WIDTH-1:0], dvs_q);

	// anything past the divergence bound, saturated or not, falls back to nominal
	assign over  = dvd_q > PROD_WIDTH'(limit);
	assign q_val = neg_q ? -$signed(dvd_q[MT_WIDTH-1:0]) : $signed(dvd_q[MT_WIDTH-1:0]);

	always_comb begin
		unique case (mode_q)
			LANE_START:  mt_next = nominal;
			LANE_REFINE: mt_next = (zero_q || over) ? nominal : q_val;
			default:     mt_next = mt_q;
		endcase
	end

	assign dur_prod = DPROD_W'(mt_mag) * DPROD_W'(TICKS_PER_UNIT);
	assign in_tol   = CMP_WIDTH'(ang_mag) < CMP_WIDTH'(tolerance);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			L_IDLE: begin
				if (go) begin
					state_d = (mode == LANE_REFINE) ? L_MUL : L_FIX;
				end
			end
			L_MUL: state_d = L_DIV;
			L_DIV: begin
				if (cnt_q == CNT_WIDTH'(DIV_STEPS - 1)) begin
					state_d = L_FIX;
				end
			end
			L_FIX:   state_d = L_OUT;
			L_OUT:   state_d = L_IDLE;
			default: state_d = L_IDLE;
		endcase
	end

	always_comb begin
		capture_en = 1'b0;
		mul_en     = 1'b0;
		div_en     = 1'b0;
		fix_en     = 1'b0;
		out_en     = 1'b0;
		unique case (state_q)
			L_IDLE:  capture_en = go;
			L_MUL:   mul_en     = 1'b1;
			L_DIV:   div_en     = 1'b1;
			L_FIX:   fix_en     = 1'b1;
			L_OUT:   out_en     = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			mode_q  <= LANE_HOLD;
			last_q  <= '0;
			mt_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= out_en;
			if (capture_en) begin
				mode_q <= mode;
			end
			if (fix_en) begin
				mt_q <= mt_next;
				if (mode_q != LANE_HOLD) begin
					last_q <= angle_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture_en) begin
			angle_q <= angle;
		end
		if (mul_en) begin
			dvd_q  <= prod_mag;
			rem_q  <= '0;
			dvs_q  <= diff_mag;
			neg_q  <= angle_q[ANGLE_WIDTH-1] ^ mt_q[MT_WIDTH-1] ^ diff[DVS_WIDTH-1];
			zero_q <= (diff == '0);
			cnt_q  <= '0;
		end
		if (div_en) begin
			rem_q <= step2[STEP_W-1 -: REM_WIDTH];
			dvd_q <= step2[PROD_WIDTH-1:0];
			cnt_q <= cnt_q + CNT_WIDTH'(1);
		end
		if (out_en) begin
			res_q.in_tol <= in_tol;
			if (in_tol) begin
				res_q.drive    <= DRV_NONE;
				res_q.duration <= '0;
			end else begin
				res_q.drive    <= angle_q[ANGLE_WIDTH-1] ? DRV_CW : DRV_CCW;
				res_q.duration <= dur_prod[TIME_FRAC_BITS +: DUR_WIDTH];
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

>>> src/shc_merge.sv
// Merging stage: combines the two axis results into the run status and
// the gated motor commands. Depends on shc_pkg.
module shc_merge
	import shc_pkg::*;
(
	input  logic                  active,
	input  logic [ITER_WIDTH-1:0] iter_count,
	input  logic [ITER_WIDTH-1:0] max_iterations,
	input  lane_res_t             res_x,
	input  lane_res_t             res_y,
	output merge_ctl_t            ctl,
	output lane_res_t             cmd_x,
	output lane_res_t             cmd_y
);

	lane_res_t idle_cmd;

	assign idle_cmd = '{drive: DRV_NONE, duration: '0, in_tol: 1'b1};

	always_comb begin
		ctl   = '{status: ST_IDLE, run_active: 1'b0, iter_inc: 1'b0};
		cmd_x = idle_cmd;
		cmd_y = idle_cmd;
		// limit takes precedence over convergence
		priority if (!active) begin
			ctl.status = ST_IDLE;
		end else if (iter_count >= max_iterations) begin
			ctl.status = ST_LIMIT;
		end else if (res_x.in_tol && res_y.in_tol) begin
			ctl.status = ST_CONVERGED;
		end else begin
			ctl.status     = ST_MOVING;
			ctl.run_active = 1'b1;
			ctl.iter_inc   = 1'b1;
			cmd_x          = res_x;
			cmd_y          = res_y;
		end
	end

endmodule

>>> src/secant_homing_controller_unit.sv
// Two-axis secant homing controller: two axis lanes and the merging stage.
// Depends on shc_pkg, shc_lane, shc_merge and the assertion macro header.
//
// Each accepted tilt pair yields one command. An item inside a run that is
// not a start passes through the 40-bit restoring divider of each axis lane,
// which retires two quotient bits a cycle; start items and items outside a
// run skip the divider. No new item is taken until the last one is merged.
// A finished command waits in the output register, and the next item is
// taken while it waits; only the merge of a further result holds until the
// output is free. Configuration may be written whenever the block is idle
// and takes effect on the next item.
`include "secant_homing_controller_unit_defines.svh"

module secant_homing_controller_unit
	import shc_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          start_req,
	input  logic signed [ANGLE_WIDTH-1:0] angle_x,
	input  logic signed [ANGLE_WIDTH-1:0] angle_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    drive_x,
	output logic [DUR_WIDTH-1:0]          duration_x,
	output logic [1:0]                    drive_y,
	output logic [DUR_WIDTH-1:0]          duration_y,
	output logic [1:0]                    run_status,
	input  logic                          cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]     cfg_data
);

	top_state_t            state_q, state_d;
	logic [STEP_WIDTH-1:0] step_time_q;
	logic [ITER_WIDTH-1:0] max_iter_q;
	logic [TOL_WIDTH-1:0]  tolerance_q;
	logic                  run_active_q;
	logic [ITER_WIDTH-1:0] iter_q;
	logic                  active_q;
	logic                  out_valid_q;
	lane_res_t             out_x_q, out_y_q;
	status_t               out_status_q;

	logic       accept;
	logic       load;
	lane_mode_t lane_mode;
	logic       lane_done_x, lane_done_y;
	lane_res_t  lane_res_x, lane_res_y;
	merge_ctl_t ctl;
	lane_res_t  cmd_x, cmd_y;

	assign accept    = in_valid && in_ready;
	assign lane_mode = start_req ? LANE_START : (run_active_q ? LANE_REFINE : LANE_HOLD);

	shc_lane u_lane_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (accept),
		.mode      (lane_mode),
		.angle     (angle_x),
		.step_time (step_time_q),
		.tolerance (tolerance_q),
		.done      (lane_done_x),
		.res       (lane_res_x)
	);

	shc_lane u_lane_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (accept),
		.mode      (lane_mode),
		.angle     (angle_y),
		.step_time (step_time_q),
		.tolerance (tolerance_q),
		.done      (lane_done_y),
		.res       (lane_res_y)
	);

	shc_merge u_merge (
		.active         (active_q),
		.iter_count     (iter_q),
		.max_iterations (max_iter_q),
		.res_x          (lane_res_x),
		.res_y          (lane_res_y),
		.ctl            (ctl),
		.cmd_x          (cmd_x),
		.cmd_y          (cmd_y)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			T_IDLE: begin
				if (accept) begin
					state_d = T_BUSY;
				end
			end
			T_BUSY: begin
				if (lane_done_x) begin
					state_d = T_MERGE;
				end
			end
			T_MERGE: begin
				if (!out_valid_q || out_ready) begin
					state_d = T_IDLE;
				end
			end
			default: state_d = T_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		load     = 1'b0;
		unique case (state_q)
			T_IDLE:  in_ready = 1'b1;
			T_BUSY:  ;
			T_MERGE: load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= T_IDLE;
			step_time_q  <= STEP_TIME_RST;
			max_iter_q   <= MAX_ITER_RST;
			tolerance_q  <= TOLERANCE_RST;
			run_active_q <= 1'b0;
			iter_q       <= '0;
			active_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_STEP_TIME: step_time_q <= cfg_data[STEP_WIDTH-1:0];
					CFG_MAX_ITER:  max_iter_q  <= cfg_data[ITER_WIDTH-1:0];
					CFG_TOLERANCE: tolerance_q <= cfg_data[TOL_WIDTH-1:0];
					default:       ;
				endcase
			end
			if (accept) begin
				active_q <= start_req || run_active_q;
				// a start restarts the run count
				if (start_req) begin
					iter_q <= '0;
				end
			end
			if (load) begin
				run_active_q <= ctl.run_active;
				out_valid_q  <= 1'b1;
				if (ctl.iter_inc) begin
					iter_q <= iter_q + ITER_WIDTH'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_x_q      <= cmd_x;
			out_y_q      <= cmd_y;
			out_status_q <= ctl.status;
		end
	end

	assign out_valid  = out_valid_q;
	assign drive_x    = out_x_q.drive;
	assign duration_x = out_x_q.duration;
	assign drive_y    = out_y_q.drive;
	assign duration_y = out_y_q.duration;
	assign run_status = out_status_q;

	`SHC_ASSERT_SAME(a_lanes_in_step, lane_done_x || lane_done_y, lane_done_x && lane_done_y, "axis lanes finished apart")
	`SHC_ASSERT_SAME(a_idle_cmd, out_valid && (run_status != ST_MOVING), (drive_x == DRV_NONE) && (drive_y == DRV_NONE) && (duration_x == '0) && (duration_y == '0), "motor command outside a move")
	`SHC_ASSERT_NEXT(a_run_flag, load, run_active_q == (run_status == ST_MOVING), "run flag disagrees with status")

endmodule

>>> dv/tb_secant_homing_controller_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for secant_homing_controller_unit: predicts every motor command.
// Needs shc_pkg and the controller RTL only.

module tb_secant_homing_controller_unit;
	import shc_pkg::*;

	localparam int     ANG_MAX     = (1 << (ANGLE_WIDTH - 1)) - 1;
	localparam int     ANG_MIN     = -(1 << (ANGLE_WIDTH - 1));
	localparam longint MT_MAX      = (longint'(1) <<< (MT_WIDTH - 1)) - 1;
	localparam longint MT_MIN      = -MT_MAX - 1;
	localparam int     STALL_LIMIT = 2000;
	localparam int     TAIL_CYCLES = 40;

	typedef struct {
		logic                          start;
		logic signed [ANGLE_WIDTH-1:0] ax;
		logic signed [ANGLE_WIDTH-1:0] ay;
	} tilt_t;

	typedef struct {
		drive_t               dx;
		logic [DUR_WIDTH-1:0] tx;
		drive_t               dy;
		logic [DUR_WIDTH-1:0] ty;
		status_t              st;
	} motor_cmd_t;

	logic                          clk        = 1'b0;
	logic                          arst_n     = 1'b0;
	logic                          in_valid   = 1'b0;
	logic                          in_ready;
	logic                          start_req  = 1'b0;
	logic signed [ANGLE_WIDTH-1:0] angle_x    = '0;
	logic signed [ANGLE_WIDTH-1:0] angle_y    = '0;
	logic                          out_valid;
	logic                          out_ready  = 1'b0;
	logic [1:0]                    drive_x;
	logic [DUR_WIDTH-1:0]          duration_x;
	logic [1:0]                    drive_y;
	logic [DUR_WIDTH-1:0]          duration_y;
	logic [1:0]                    run_status;
	logic                          cfg_we     = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0]    cfg_index  = '0;
	logic [CFG_DATA_WIDTH-1:0]     cfg_data   = '0;

	secant_homing_controller_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_req  (start_req),
		.angle_x    (angle_x),
		.angle_y    (angle_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.drive_x    (drive_x),
		.duration_x (duration_x),
		.drive_y    (drive_y),
		.duration_y (duration_y),
		.run_status (run_status),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// Predictor copy of the registers and the homing state
	logic [STEP_WIDTH-1:0]         step_time_q = STEP_TIME_RST;
	logic [ITER_WIDTH-1:0]         max_iter_q  = MAX_ITER_RST;
	logic [TOL_WIDTH-1:0]          tol_q       = TOLERANCE_RST;
	logic signed [ANGLE_WIDTH-1:0] last_x      = '0;
	logic signed [ANGLE_WIDTH-1:0] last_y      = '0;
	logic signed [MT_WIDTH-1:0]    mt_x        = '0;
	logic signed [MT_WIDTH-1:0]    mt_y        = '0;
	logic [ITER_WIDTH-1:0]         moves_done  = '0;
	logic                          homing      = 1'b0;

	tilt_t      pending_tilts[$];
	motor_cmd_t expected_cmds[$];
	tilt_t      held_tilt;
	motor_cmd_t want;
	logic       idle_enable = 1'b1;
	int         gap_left    = 0;
	int         stall_left  = 0;
	int         quiet_cycles = 0;
	int         errors      = 0;

	function automatic longint magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint secant_update(input longint angle, input longint prev,
		input longint mt);
		longint nominal;
		longint diff;
		longint q;
		nominal = longint'(step_time_q) << TIME_FRAC_BITS;
		diff = angle - prev;
		if (diff == 0)
			return nominal;
		q = (angle * mt) / diff;
		if (q > MT_MAX)
			q = MT_MAX;
		if (q < MT_MIN)
			q = MT_MIN;
		// pull a runaway estimate back to the nominal time
		if (magnitude(q) > nominal * DIVERGE_FACTOR)
			q = nominal;
		return q;
	endfunction

	function automatic void axis_move(input longint angle, input longint mt,
		output drive_t drv, output logic [DUR_WIDTH-1:0] dur);
		if (magnitude(angle) < longint'(tol_q)) begin
			drv = DRV_NONE;
			dur = '0;
		end else begin
			drv = (angle < 0) ? DRV_CW : DRV_CCW;
			dur = DUR_WIDTH'((magnitude(mt) * TICKS_PER_UNIT) >>> TIME_FRAC_BITS);
		end
	endfunction

	function automatic motor_cmd_t predict_command(input tilt_t it);
		motor_cmd_t c;
		longint ax;
		longint ay;
		ax = it.ax;
		ay = it.ay;
		c.dx = DRV_NONE;
		c.tx = '0;
		c.dy = DRV_NONE;
		c.ty = '0;
		c.st = ST_IDLE;
		if (it.start) begin
			mt_x = MT_WIDTH'(longint'(step_time_q) << TIME_FRAC_BITS);
			mt_y = mt_x;
			moves_done = '0;
			homing = 1'b1;
		end else if (homing) begin
			mt_x = MT_WIDTH'(secant_update(ax, last_x, mt_x));
			mt_y = MT_WIDTH'(secant_update(ay, last_y, mt_y));
		end
		if (homing) begin
			last_x = it.ax;
			last_y = it.ay;
			if (moves_done >= max_iter_q) begin
				c.st = ST_LIMIT;
				homing = 1'b0;
			end else if (magnitude(ax) < longint'(tol_q) && magnitude(ay) < longint'(tol_q)) begin
				c.st = ST_CONVERGED;
				homing = 1'b0;
			end else begin
				c.st = ST_MOVING;
				axis_move(ax, mt_x, c.dx, c.tx);
				axis_move(ay, mt_y, c.dy, c.ty);
				moves_done = moves_done + 1'b1;
			end
		end
		return c;
	endfunction

	// Sender: predict on each transfer, then present the next tilt pair
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready)
				expected_cmds.push_back(predict_command(held_tilt));
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (idle_enable && pending_tilts.size() > 0
					&& $urandom_range(0, 4) == 0) begin
					gap_left = $urandom_range(0, 8);
					in_valid <= 1'b0;
				end else if (pending_tilts.size() > 0) begin
					held_tilt = pending_tilts.pop_front();
					in_valid <= 1'b1;
					start_req <= held_tilt.start;
					angle_x <= held_tilt.ax;
					angle_y <= held_tilt.ay;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each command against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_cmds.size() == 0) begin
					$error("unexpected command: drive_x %0d duration_x %0d drive_y %0d duration_y %0d status %0d",
						drive_x, duration_x, drive_y, duration_y, run_status);
					errors++;
				end else begin
					want = expected_cmds.pop_front();
					if (drive_x !== want.dx) begin
						$error("drive_x: expected %0d, actual %0d", want.dx, drive_x);
						errors++;
					end
					if (duration_x !== want.tx) begin
						$error("duration_x: expected %0d, actual %0d", want.tx, duration_x);
						errors++;
					end
					if (drive_y !== want.dy) begin
						$error("drive_y: expected %0d, actual %0d", want.dy, drive_y);
						errors++;
					end
					if (duration_y !== want.ty) begin
						$error("duration_y: expected %0d, actual %0d", want.ty, duration_y);
						errors++;
					end
					if (run_status !== want.st) begin
						$error("run_status: expected %0d, actual %0d", want.st, run_status);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_enable && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 8);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Abort when no transfer happens on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	function automatic logic signed [ANGLE_WIDTH-1:0] clamp_angle(input int v);
		if (v > ANG_MAX)
			return ANGLE_WIDTH'(ANG_MAX);
		if (v < ANG_MIN)
			return ANGLE_WIDTH'(ANG_MIN);
		return ANGLE_WIDTH'(v);
	endfunction

	function automatic int rand_angle();
		int t;
		t = int'(tol_q);
		case ($urandom_range(0, 4))
			0: return int'($urandom_range(0, 65535)) + ANG_MIN;
			1: return $urandom_range(0, 1) ? ANG_MAX : ANG_MIN;
			2: return clamp_angle(int'($urandom_range(0, 2 * t + 2)) - (t + 1));
			default: return int'($urandom_range(0, 8000)) - 4000;
		endcase
	endfunction

	// Next measurement of a run: mostly closer to home, sometimes stuck or jumping
	function automatic int next_angle(input int prev);
		int v;
		case ($urandom_range(0, 7))
			0: return prev;
			1: return rand_angle();
			default: begin
				v = prev * int'($urandom_range(0, 7)) / 8;
				if ($urandom_range(0, 3) == 0)
					v = -v;
				return clamp_angle(v + int'($urandom_range(0, 64)) - 32);
			end
		endcase
	endfunction

	task automatic add_tilt(input logic s, input int ax, input int ay);
		tilt_t it;
		it.start = s;
		it.ax = clamp_angle(ax);
		it.ay = clamp_angle(ay);
		pending_tilts.push_back(it);
	endtask

	task automatic queue_random_tilts(input int count);
		int added;
		int len;
		int ax;
		int ay;
		added = 0;
		while (added < count) begin
			if ($urandom_range(0, 4) != 0) begin
				ax = rand_angle();
				ay = rand_angle();
				add_tilt(1'b1, ax, ay);
				added++;
				len = $urandom_range(1, 12);
				repeat (len) begin
					ax = next_angle(ax);
					ay = next_angle(ay);
					add_tilt(1'b0, ax, ay);
					added++;
				end
			end else begin
				add_tilt(1'($urandom_range(0, 1)), rand_angle(), rand_angle());
				added++;
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_WIDTH'(value);
		case (idx)
			CFG_STEP_TIME: step_time_q = STEP_WIDTH'(value);
			CFG_MAX_ITER:  max_iter_q = ITER_WIDTH'(value);
			CFG_TOLERANCE: tol_q = TOL_WIDTH'(value);
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(input int unsigned st, input int unsigned mi, input int unsigned tl);
		write_reg(CFG_STEP_TIME, st);
		write_reg(CFG_MAX_ITER, mi);
		write_reg(CFG_TOLERANCE, tl);
	endtask

	// Hold until the sender has nothing left and every command has come back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_tilts.size() != 0 || in_valid || expected_cmds.size() != 0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: idle items, run start, stuck angle, secant steps, endings
		add_tilt(1'b0, ANG_MIN, ANG_MAX);
		add_tilt(1'b0, 0, 0);
		add_tilt(1'b1, ANG_MAX, ANG_MIN);
		add_tilt(1'b0, ANG_MAX, ANG_MIN);
		add_tilt(1'b0, -16384, 16000);
		add_tilt(1'b0, -16383, 16001);
		add_tilt(1'b0, 50, 5000);
		add_tilt(1'b0, 101, -101);
		add_tilt(1'b0, 3000, 3000);
		add_tilt(1'b1, 0, 0);
		add_tilt(1'b1, 101, -102);
		add_tilt(1'b1, -5000, 7000);
		add_tilt(1'b0, -2500, 3500);
		add_tilt(1'b0, -102, 102);
		add_tilt(1'b0, -1, 1);
		wait_drained();

		// no moves allowed: the start item already hits the limit, even at home
		write_reg(CFG_MAX_ITER, 0);
		add_tilt(1'b1, 4000, -4000);
		add_tilt(1'b1, 0, 0);
		add_tilt(1'b0, 4000, 4000);
		wait_drained();

		// limit reached on the same item that would converge
		write_reg(CFG_MAX_ITER, 2);
		add_tilt(1'b1, 8000, -8000);
		add_tilt(1'b0, 4000, -4000);
		add_tilt(1'b0, 10, 10);
		wait_drained();

		write_all(10, 10, 102);
		queue_random_tilts(110);
		wait_drained();

		write_all(0, (1 << ITER_WIDTH) - 1, 0);
		queue_random_tilts(110);
		wait_drained();

		write_all((1 << STEP_WIDTH) - 1, 5000, (1 << TOL_WIDTH) - 1);
		queue_random_tilts(110);
		wait_drained();

		write_all(1, 1, 1);
		queue_random_tilts(110);
		wait_drained();

		idle_enable = 1'b0;
		write_all($urandom_range(0, 4095), $urandom_range(0, 20), $urandom_range(0, 2000));
		queue_random_tilts(110);
		wait_drained();

		idle_enable = 1'b1;
		write_all((1 << STEP_WIDTH) - 1, 20, 500);
		queue_random_tilts(110);
		wait_drained();

		write_all($urandom_range(0, 4095), $urandom_range(0, 8191), 10240);
		queue_random_tilts(110);
		wait_drained();

		// closing stretch at full rate on both sides
		idle_enable = 1'b0;
		write_all($urandom_range(1, 64), $urandom_range(3, 15), $urandom_range(50, 400));
		queue_random_tilts(110);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
